// ----- sv/pathnorm_pkg.sv -----
package pathnorm_pkg;

  // Path characters with a meaning of their own
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Parser position within a component
  typedef enum logic [1:0] {
    PH_SEP,
    PH_DOT1,
    PH_DOT2,
    PH_NAME
  } phase_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_OPEN,
    CMD_UP,
    CMD_END
  } cmd_kind_t;

  // Closing action of a path, carried by the end command
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_UP,
    FIN_SLASH
  } fin_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_ROOT = 2'd2
  } status_t;

  // Back end sequencer
  typedef enum logic {
    BK_BUILD,
    BK_EMIT
  } back_state_t;

  // nchar: characters after the opening '/' of a new component (1..3)
  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] nchar;
    fin_t       fin;
    logic [7:0] ch;
  } cmd_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/path_normalizer_top.sv -----
// Path normalizer: collapses a character stream into a normalized Unix path.
// Input channel s_*: one path character per item in s_tdata; an item with
// s_tlast set ends the path and its data byte is ignored.
// Output channel m_*: the normalized path, one character per item, m_tlast
// on the final one; or one item with m_tuser low for an empty path or an
// error (status in m_tdata[9:8]: 1 path too long, 2 above root).
// Config channel cfg_*: buffer_limit, taken whenever cfg_valid is high;
// write it only while no path is in flight.
// Throughput: one character per cycle while a path is parsed and the
// queue has room. The front end classifies characters into commands for
// a 4-entry queue; the back end writes up to four bytes a cycle into four
// interleaved byte banks. After the end item the back end closes the path,
// then streams n results at one per cycle while m_tready is high, reading
// the banks through a registered read port; the first result follows the
// end item through the emit state and the output registers. Input keeps
// flowing into the queue during output, until it holds 4 commands.
// Reset clears parser, queue and result state; buffer_limit returns to 64.
// A stalled m_tready holds the current result; the queue then backs up and
// drops s_tready once full.
module path_normalizer_top #(
  parameter int BUF_DEPTH      = 64,
  parameter int MAX_COMPONENTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [7:0] char_value; s_tlast: end_of_path
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // m_tdata: [7:0] out_char, [9:8] status, [15:10] component_count
  // m_tuser: char_valid; m_tlast: last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic [6:0]            buffer_limit;
  logic                  push, pop;
  pathnorm_pkg::cmd_t    push_cmd, head;
  pathnorm_pkg::q_stat_t q_stat;
  logic [7:0]            out_char;
  pathnorm_pkg::status_t status;
  logic [5:0]            component_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {component_count, status, out_char};

  // Buffer limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      buffer_limit <= cfg_data;
    end
  end

  pathnorm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .in_end   (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pathnorm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  pathnorm_back #(
    .BUF_DEPTH      (BUF_DEPTH),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .buffer_limit    (buffer_limit),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_char        (out_char),
    .char_valid      (m_tuser),
    .last_item       (m_tlast),
    .status          (status),
    .component_count (component_count)
  );

`ifndef ASSERT_OFF
  // Empty and error results always close the path
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("error result without last");

  // Character results always carry an ok status
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[9:8] == pathnorm_pkg::ST_OK))
    else $error("character result with error status");

  // Empty and error results report no components
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[15:10] == 6'd0))
    else $error("error result with nonzero component count");
`endif

endmodule

// ----- sv/pathnorm_front.sv -----
module pathnorm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  logic                in_end,
  input  pathnorm_pkg::q_stat_t q_stat,
  output logic                push,
  output pathnorm_pkg::cmd_t  push_cmd
);

  pathnorm_pkg::phase_t phase, phase_next;
  logic slash_seen, slash_seen_next;
  logic acc;
  logic is_slash, is_dot;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign is_slash = (in_char == pathnorm_pkg::CH_SLASH);
  assign is_dot   = (in_char == pathnorm_pkg::CH_DOT);

  // Classify each character against the parser phase
  always_comb begin
    phase_next      = phase;
    slash_seen_next = slash_seen;
    push            = 1'b0;
    push_cmd.kind   = pathnorm_pkg::CMD_PUT;
    push_cmd.nchar  = 2'd1;
    push_cmd.fin    = pathnorm_pkg::FIN_NONE;
    push_cmd.ch     = in_char;
    if (acc) begin
      if (in_end) begin
        push          = 1'b1;
        push_cmd.kind = pathnorm_pkg::CMD_END;
        if (phase == pathnorm_pkg::PH_DOT2) begin
          push_cmd.fin = pathnorm_pkg::FIN_UP;
        end else if (phase == pathnorm_pkg::PH_SEP && slash_seen) begin
          push_cmd.fin = pathnorm_pkg::FIN_SLASH;
        end
        phase_next      = pathnorm_pkg::PH_SEP;
        slash_seen_next = 1'b0;
      end else begin
        case (phase)
          pathnorm_pkg::PH_NAME: begin
            if (is_slash) begin
              phase_next      = pathnorm_pkg::PH_SEP;
              slash_seen_next = 1'b1;
            end else begin
              push = 1'b1;
            end
          end
          pathnorm_pkg::PH_DOT1: begin
            if (is_slash) begin
              phase_next      = pathnorm_pkg::PH_SEP;
              slash_seen_next = 1'b1;
            end else if (is_dot) begin
              phase_next = pathnorm_pkg::PH_DOT2;
            end else begin
              push           = 1'b1;
              push_cmd.kind  = pathnorm_pkg::CMD_OPEN;
              push_cmd.nchar = 2'd2;
              phase_next     = pathnorm_pkg::PH_NAME;
            end
          end
          pathnorm_pkg::PH_DOT2: begin
            if (is_slash) begin
              push            = 1'b1;
              push_cmd.kind   = pathnorm_pkg::CMD_UP;
              phase_next      = pathnorm_pkg::PH_SEP;
              slash_seen_next = 1'b1;
            end else begin
              push           = 1'b1;
              push_cmd.kind  = pathnorm_pkg::CMD_OPEN;
              push_cmd.nchar = 2'd3;
              phase_next     = pathnorm_pkg::PH_NAME;
            end
          end
          default: begin
            if (is_slash) begin
              slash_seen_next = 1'b1;
            end else if (is_dot) begin
              phase_next      = pathnorm_pkg::PH_DOT1;
              slash_seen_next = 1'b0;
            end else begin
              push            = 1'b1;
              push_cmd.kind   = pathnorm_pkg::CMD_OPEN;
              push_cmd.nchar  = 2'd1;
              phase_next      = pathnorm_pkg::PH_NAME;
              slash_seen_next = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pathnorm_pkg::PH_SEP;
      slash_seen <= 1'b0;
    end else begin
      phase      <= phase_next;
      slash_seen <= slash_seen_next;
    end
  end

endmodule

// ----- sv/pathnorm_queue.sv -----
module pathnorm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pathnorm_pkg::cmd_t    push_cmd,
  input  logic                  pop,
  output pathnorm_pkg::cmd_t    head,
  output pathnorm_pkg::q_stat_t q_stat
);

  pathnorm_pkg::cmd_t entry [pathnorm_pkg::QDEPTH];
  logic [pathnorm_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [pathnorm_pkg::QAW:0]   count;

  assign head         = entry[rd_ptr];
  assign q_stat.full  = (count == (pathnorm_pkg::QAW+1)'(pathnorm_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (pathnorm_pkg::QAW+1)'(push) - (pathnorm_pkg::QAW+1)'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

endmodule

// ----- sv/pathnorm_back.sv -----
module pathnorm_back #(
  parameter int BUF_DEPTH      = 64,
  parameter int MAX_COMPONENTS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pathnorm_pkg::cmd_t      head,
  input  pathnorm_pkg::q_stat_t   q_stat,
  output logic                    pop,
  input  logic [6:0]              buffer_limit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_char,
  output logic                    char_valid,
  output logic                    last_item,
  output pathnorm_pkg::status_t   status,
  output logic [5:0]              component_count
);

  localparam int FW   = $clog2(BUF_DEPTH);
  localparam int ROWS = (BUF_DEPTH + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DW   = $clog2(MAX_COMPONENTS + 1);
  localparam int SW   = $clog2(MAX_COMPONENTS);

  pathnorm_pkg::back_state_t state, state_next;
  pathnorm_pkg::status_t     err, err_next, st_next;
  logic [FW-1:0] fill, fill_next, idx, idx_next;
  logic [DW-1:0] depth, depth_next, depth_m1;
  logic          single, single_next;
  logic          ov_next, cv_next, last_next;
  logic [5:0]    cnt_next;
  logic [1:0]    sel, sel_next;
  logic [FW-1:0] stack [MAX_COMPONENTS];
  logic [FW-1:0] stack_top;
  logic [7:0]    bank_q [4];
  logic [7:0]    wbyte [4];
  logic [2:0]    wr_t;
  logic          is_open, do_up, is_end;
  logic          wr_en, push_en, rd_en, adv, done;
  logic [7:0]    eff;
  logic [RW-1:0] rd_row;

  assign eff = ({1'b0, buffer_limit} > 8'(BUF_DEPTH)) ? 8'(BUF_DEPTH) : {1'b0, buffer_limit};
  assign depth_m1  = depth - DW'(1);
  assign stack_top = stack[depth_m1[SW-1:0]];
  assign rd_row    = RW'(idx >> 2);
  assign out_char  = char_valid ? bank_q[sel] : 8'h00;

  // Decode the head command into bytes to write and stack action
  always_comb begin
    wr_t    = 3'd0;
    is_open = 1'b0;
    do_up   = 1'b0;
    is_end  = 1'b0;
    for (int j = 0; j < 4; j++) begin
      wbyte[j] = pathnorm_pkg::CH_DOT;
    end
    case (head.kind)
      pathnorm_pkg::CMD_PUT: begin
        wr_t     = 3'd1;
        wbyte[0] = head.ch;
      end
      pathnorm_pkg::CMD_OPEN: begin
        is_open  = 1'b1;
        wr_t     = 3'(head.nchar) + 3'd1;
        wbyte[0] = pathnorm_pkg::CH_SLASH;
        for (int j = 1; j < 4; j++) begin
          if (2'(j) == head.nchar) wbyte[j] = head.ch;
        end
      end
      pathnorm_pkg::CMD_UP: begin
        do_up = 1'b1;
      end
      pathnorm_pkg::CMD_END: begin
        is_end = 1'b1;
        case (head.fin)
          pathnorm_pkg::FIN_UP: begin
            do_up = 1'b1;
          end
          pathnorm_pkg::FIN_SLASH: begin
            wr_t     = 3'd1;
            wbyte[0] = pathnorm_pkg::CH_SLASH;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencer: build the path from commands, then stream it out
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    depth_next  = depth;
    err_next    = err;
    idx_next    = idx;
    single_next = single;
    ov_next     = out_valid;
    cv_next     = char_valid;
    last_next   = last_item;
    st_next     = status;
    cnt_next    = component_count;
    sel_next    = sel;
    pop         = 1'b0;
    wr_en       = 1'b0;
    push_en     = 1'b0;
    rd_en       = 1'b0;
    done        = 1'b0;
    adv         = !out_valid || out_ready;
    if (out_valid && out_ready) ov_next = 1'b0;
    case (state)
      pathnorm_pkg::BK_BUILD: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (err == pathnorm_pkg::ST_OK) begin
            if (do_up) begin
              if (fill == '0 || depth == '0) begin
                err_next = pathnorm_pkg::ST_ROOT;
              end else begin
                depth_next = depth_m1;
                fill_next  = stack_top;
              end
            end else if (wr_t != 3'd0) begin
              if (is_open && depth >= DW'(MAX_COMPONENTS)) begin
                err_next = pathnorm_pkg::ST_LONG;
              end else if (8'(fill) + 8'(wr_t) >= eff) begin
                err_next = pathnorm_pkg::ST_LONG;
              end else begin
                wr_en     = 1'b1;
                fill_next = fill + FW'(wr_t);
                if (is_open) begin
                  push_en    = 1'b1;
                  depth_next = depth + DW'(1);
                end
              end
            end
          end
          if (is_end) begin
            if (buffer_limit == 7'd0) err_next = pathnorm_pkg::ST_LONG;
            state_next  = pathnorm_pkg::BK_EMIT;
            single_next = (err_next != pathnorm_pkg::ST_OK) || (fill_next == '0);
            idx_next    = '0;
          end
        end
      end
      pathnorm_pkg::BK_EMIT: begin
        if (adv) begin
          ov_next = 1'b1;
          if (single) begin
            cv_next   = 1'b0;
            last_next = 1'b1;
            st_next   = err;
            cnt_next  = 6'd0;
            done      = 1'b1;
          end else begin
            rd_en     = 1'b1;
            sel_next  = idx[1:0];
            cv_next   = 1'b1;
            st_next   = pathnorm_pkg::ST_OK;
            cnt_next  = (fill == FW'(1)) ? 6'd1 : 6'(depth);
            last_next = ((idx + FW'(1)) == fill);
            idx_next  = idx + FW'(1);
            done      = last_next;
          end
          if (done) begin
            state_next = pathnorm_pkg::BK_BUILD;
            fill_next  = '0;
            depth_next = '0;
            err_next   = pathnorm_pkg::ST_OK;
            idx_next   = '0;
          end
        end
      end
      default: begin
        state_next = pathnorm_pkg::BK_BUILD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pathnorm_pkg::BK_BUILD;
      fill      <= '0;
      depth     <= '0;
      err       <= pathnorm_pkg::ST_OK;
      idx       <= '0;
      single    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      depth     <= depth_next;
      err       <= err_next;
      idx       <= idx_next;
      single    <= single_next;
      out_valid <= ov_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    char_valid      <= cv_next;
    last_item       <= last_next;
    status          <= st_next;
    component_count <= cnt_next;
    sel             <= sel_next;
  end

  // Component start positions
  always_ff @(posedge clk) begin
    if (push_en) stack[depth[SW-1:0]] <= fill;
  end

  // Four interleaved byte banks: up to four consecutive bytes per cycle
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    off;
    logic [FW-1:0] waddr;
    logic          we;

    assign off   = 2'(b) - fill[1:0];
    assign waddr = fill + FW'(off);
    assign we    = wr_en && ({1'b0, off} < wr_t);

    always_ff @(posedge clk) begin
      if (we)    mem[RW'(waddr >> 2)] <= wbyte[off];
      if (rd_en) bank_q[b] <= mem[rd_row];
    end
  end

endmodule
